### hw/rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int FILL_W   = 9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_READ       = 3'd4,
    ACT_WRITE      = 3'd5
  } dq_action_t;

  // Store access decided for one beat.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic err;
  } dq_req_t;

endpackage

### hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: store, pointer control and result stage.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   in_action, in_position, in_word_in
//  out_     output     out_valid / out_ready out_word_out, out_fill_count, out_error
//
// Flow: one beat per cycle while the result side keeps up; a result leaves
//   through the RAM read stage (decode and store access), then the result register.
// The store is a RAM of DEPTH words, at most one access per beat. Pointer and count
//   update at acceptance, so the next beat sees them at once; a write is in
//   the RAM before any later read of the same entry is issued.
// Reset clears the front pointer, the count and the valid flags. The store is
//   not cleared; no action reaches an entry that was never written.
// Stalls: while a result waits on out_ready and another sits behind it in the
//   RAM read stage, in_ready drops.
module double_ended_queue #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dq_pkg::ACTION_W-1:0]  in_action,
  input  logic [dq_pkg::POS_W-1:0]     in_position,
  input  logic [dq_pkg::DATA_W-1:0]    in_word_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dq_pkg::DATA_W-1:0]    out_word_out,
  output logic [dq_pkg::FILL_W-1:0]    out_fill_count,
  output logic                         out_error
);
  import dq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                 accept;
  dq_req_t              req;
  logic [PTR_W-1:0]     addr;
  logic [CNT_W-1:0]     occ_after;
  logic [WORD_BITS-1:0] rdata;

  // Read stage: beat whose RAM read data shows up this cycle.
  logic              pend_r, pend_nxt;
  logic              pend_rd_r;
  logic              pend_err_r;
  logic [FILL_W-1:0] pend_fill_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_word_r;
  logic [FILL_W-1:0] out_fill_r;
  logic              out_err_r;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !pend_r || out_free;
  assign accept   = in_valid && in_ready;

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .position  (in_position),
    .req       (req),
    .addr      (addr),
    .occ_after (occ_after)
  );

  // Words are kept to WORD_BITS bits in the store.
  dq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (accept && req.wr_en),
    .waddr (addr),
    .wdata (WORD_BITS'(in_word_in)),
    .re    (accept && req.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  // Advance the read stage on a new beat, drop it once it moves on.
  always_comb begin
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (out_free) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  // Load the result register from the read stage, clear it once taken.
  always_comb begin
    if (pend_r && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rd_r   <= req.rd_en;
      pend_err_r  <= req.err;
      pend_fill_r <= FILL_W'(occ_after);
    end
    if (pend_r && out_free) begin
      // Only pops and reads return a word; everything else returns zero.
      out_word_r <= pend_rd_r ? DATA_W'(rdata) : '0;
      out_fill_r <= pend_fill_r;
      out_err_r  <= pend_err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_out   = out_word_r;
  assign out_fill_count = out_fill_r;
  assign out_error      = out_err_r;

endmodule

### hw/rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/dq_ctrl.sv
// Front pointer and occupancy registers, action decode and store addressing.
module dq_ctrl #(
  parameter int DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [dq_pkg::ACTION_W-1:0]   action,
  input  logic [dq_pkg::POS_W-1:0]      position,
  output dq_pkg::dq_req_t               req,
  output logic [$clog2(DEPTH)-1:0]      addr,
  output logic [$clog2(DEPTH+1)-1:0]    occ_after
);
  import dq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;

  logic             full, empty, pos_bad;
  logic [CMP_W-1:0] pos_ext;
  logic [PTR_W-1:0] front_dec, front_inc;

  // Add an offset below DEPTH to the front pointer, modulo DEPTH.
  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] offset);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign full      = (occ_r == CNT_W'(DEPTH));
  assign empty     = (occ_r == '0);
  assign pos_ext   = CMP_W'(position);
  assign pos_bad   = (pos_ext >= CMP_W'(occ_r));
  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - PTR_W'(1);
  assign front_inc = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + PTR_W'(1);

  always_comb begin
    req       = '0;
    addr      = front_r;
    front_nxt = front_r;
    occ_nxt   = occ_r;
    unique case (action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          req.err = 1'b1;
        end else begin
          req.wr_en = 1'b1;
          addr      = front_dec;
          front_nxt = front_dec;
          occ_nxt   = occ_r + CNT_W'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          req.err = 1'b1;
        end else begin
          req.wr_en = 1'b1;
          addr      = wrap(front_r, PTR_W'(occ_r));
          occ_nxt   = occ_r + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          req.err = 1'b1;
        end else begin
          req.rd_en = 1'b1;
          addr      = front_r;
          front_nxt = front_inc;
          occ_nxt   = occ_r - CNT_W'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          req.err = 1'b1;
        end else begin
          req.rd_en = 1'b1;
          addr      = wrap(front_r, PTR_W'(occ_r - CNT_W'(1)));
          occ_nxt   = occ_r - CNT_W'(1);
        end
      end
      ACT_READ: begin
        if (pos_bad) begin
          req.err = 1'b1;
        end else begin
          req.rd_en = 1'b1;
          addr      = wrap(front_r, pos_ext[PTR_W-1:0]);
        end
      end
      ACT_WRITE: begin
        if (pos_bad) begin
          req.err = 1'b1;
        end else begin
          req.wr_en = 1'b1;
          addr      = wrap(front_r, pos_ext[PTR_W-1:0]);
        end
      end
      default: begin
        req.err = 1'b1;
      end
    endcase
  end

  assign occ_after = occ_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
    end
  end

endmodule

### hw/rtl/dq_checker.sv
// Port-level assertions for the double-ended queue, bound to the top level.
module dq_checker #(
  parameter int DEPTH = 256
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dq_pkg::DATA_W-1:0]    out_word_out,
  input logic [dq_pkg::FILL_W-1:0]    out_fill_count,
  input logic                         out_error
);
  import dq_pkg::*;

  // A refused action never returns a word.
  a_err_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_word_out == '0)
    else $error("word returned with error flag");

  // The count never exceeds the store size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_fill_count) <= DEPTH)
    else $error("fill count beyond depth");

  // Reset empties the result stage.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With no result waiting the input side is open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_out)
      && $stable(out_fill_count) && $stable(out_error))
    else $error("stalled result changed");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_word_out   (out_word_out),
  .out_fill_count (out_fill_count),
  .out_error      (out_error)
);

### tb/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: directed, fill/drain and random traffic.
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH      = 256;
  localparam int IDLE_LIMIT = 400;

  // Action codes the block must refuse.
  localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [FILL_W-1:0] fill;
    logic              err;
  } dq_result_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action   = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic [DATA_W-1:0]   in_word_in  = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [DATA_W-1:0]   out_word_out;
  logic [FILL_W-1:0]   out_fill_count;
  logic                out_error;

  double_ended_queue #(
    .DEPTH     (DEPTH),
    .WORD_BITS (DATA_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_word_in     (in_word_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word_out   (out_word_out),
    .out_fill_count (out_fill_count),
    .out_error      (out_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the queue contents, kept in step with accepted input beats.
  logic [DATA_W-1:0] mirror_store [DEPTH];
  logic [POS_W-1:0]  mirror_front = '0;
  logic [FILL_W-1:0] mirror_fill  = '0;

  // Expected results, oldest first.
  dq_result_t pending_results [$];

  int error_count     = 0;
  int beats_sent      = 0;
  int results_checked = 0;
  int refused_count   = 0;
  int full_hits       = 0;
  int peak_fill       = 0;
  int burst_left      = 0;

  // Apply one action to the mirror and return the result it should produce.
  // Slots wrap naturally because the pointer is exactly POS_W bits wide.
  function automatic dq_result_t apply_to_mirror(input logic [ACTION_W-1:0] act,
                                                 input logic [POS_W-1:0]    pos,
                                                 input logic [DATA_W-1:0]   word);
    dq_result_t res;
    logic [POS_W-1:0] slot;
    res = '0;
    case (dq_action_t'(act))
      ACT_PUSH_FRONT: begin
        if (mirror_fill == DEPTH) begin
          res.err = 1'b1;
        end else begin
          mirror_front = mirror_front - 1'b1;
          mirror_store[mirror_front] = word;
          mirror_fill++;
        end
      end
      ACT_PUSH_BACK: begin
        if (mirror_fill == DEPTH) begin
          res.err = 1'b1;
        end else begin
          slot = mirror_front + POS_W'(mirror_fill);
          mirror_store[slot] = word;
          mirror_fill++;
        end
      end
      ACT_POP_FRONT: begin
        if (mirror_fill == 0) begin
          res.err = 1'b1;
        end else begin
          res.word = mirror_store[mirror_front];
          mirror_front = mirror_front + 1'b1;
          mirror_fill--;
        end
      end
      ACT_POP_BACK: begin
        if (mirror_fill == 0) begin
          res.err = 1'b1;
        end else begin
          slot = mirror_front + POS_W'(mirror_fill - 1'b1);
          res.word = mirror_store[slot];
          mirror_fill--;
        end
      end
      ACT_READ: begin
        if ({1'b0, pos} >= mirror_fill) begin
          res.err = 1'b1;
        end else begin
          slot = mirror_front + pos;
          res.word = mirror_store[slot];
        end
      end
      ACT_WRITE: begin
        if ({1'b0, pos} >= mirror_fill) begin
          res.err = 1'b1;
        end else begin
          slot = mirror_front + pos;
          mirror_store[slot] = word;
        end
      end
      default: res.err = 1'b1;
    endcase
    res.fill = mirror_fill;
    return res;
  endfunction

  // Send one beat. Bursts of random length alternate with random gaps; a zero
  // gap keeps valid high straight into the next burst.
  task automatic send_beat(input logic [ACTION_W-1:0] act,
                           input logic [POS_W-1:0]    pos,
                           input logic [DATA_W-1:0]   word);
    dq_result_t exp_res;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_action   <= act;
    in_position <= pos;
    in_word_in  <= word;
    in_valid    <= 1'b1;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (!in_ready);
    exp_res = apply_to_mirror(act, pos, word);
    pending_results.push_back(exp_res);
    beats_sent++;
    if (exp_res.err) refused_count++;
    if (exp_res.fill == DEPTH) full_hits++;
    if (int'(exp_res.fill) > peak_fill) peak_fill = exp_res.fill;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Empty-queue refusals, unused codes, word extremes, in-range and
  // out-of-range positions, then pops from both ends back to empty.
  task automatic test_directed_cases();
    send_beat(ACT_POP_FRONT, 8'd0, 32'h0);
    send_beat(ACT_POP_BACK, 8'd0, 32'h0);
    send_beat(ACT_READ, 8'd0, 32'h0);
    send_beat(ACT_WRITE, 8'd0, 32'hDEAD_BEEF);
    send_beat(ACT_UNUSED_6, 8'hFF, 32'hFFFF_FFFF);
    send_beat(ACT_UNUSED_7, 8'h00, 32'h1234_5678);
    send_beat(ACT_PUSH_BACK, 8'd0, 32'hFFFF_FFFF);
    send_beat(ACT_PUSH_FRONT, 8'hFF, 32'h0000_0000);
    send_beat(ACT_PUSH_BACK, 8'd0, 32'hA5A5_A5A5);
    send_beat(ACT_READ, 8'd0, 32'h0);
    send_beat(ACT_READ, 8'd2, 32'h0);
    send_beat(ACT_READ, 8'd3, 32'h0);
    send_beat(ACT_READ, 8'd255, 32'h0);
    send_beat(ACT_WRITE, 8'd1, 32'h5A5A_5A5A);
    send_beat(ACT_READ, 8'd1, 32'h0);
    send_beat(ACT_WRITE, 8'd3, 32'hFFFF_FFFF);
    send_beat(ACT_UNUSED_6, 8'd0, 32'h0);
    send_beat(ACT_POP_BACK, 8'd0, 32'h0);
    send_beat(ACT_POP_FRONT, 8'd0, 32'h0);
    send_beat(ACT_POP_FRONT, 8'd0, 32'h0);
    send_beat(ACT_POP_FRONT, 8'd0, 32'h0);
    send_beat(ACT_PUSH_FRONT, 8'd0, 32'h1234_5678);
    send_beat(ACT_POP_BACK, 8'd0, 32'h0);
  endtask

  // Fill to DEPTH from both ends, hit the full refusals and the top position,
  // then drain from both ends and pop once more when empty.
  task automatic test_fill_and_drain();
    for (int i = 0; i < DEPTH; i++) begin
      send_beat($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                POS_W'($urandom), $urandom);
    end
    send_beat(ACT_PUSH_FRONT, 8'd0, $urandom);
    send_beat(ACT_PUSH_BACK, 8'd0, $urandom);
    send_beat(ACT_READ, 8'd255, 32'h0);
    send_beat(ACT_WRITE, 8'd255, $urandom);
    send_beat(ACT_READ, 8'd255, 32'h0);
    send_beat(ACT_WRITE, 8'd0, $urandom);
    send_beat(ACT_READ, 8'd0, 32'h0);
    for (int i = 0; i < DEPTH; i++) begin
      send_beat($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK,
                POS_W'($urandom), $urandom);
    end
    send_beat(ACT_POP_FRONT, 8'd0, 32'h0);
  endtask

  // Random mix. Alternate grow and shrink spells so the fill level wanders
  // over the whole range; most positions land inside the current count.
  task automatic test_random_traffic(input int n_items);
    int spell_left;
    bit growing;
    int pick;
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] word;
    spell_left = 0;
    growing = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (spell_left == 0) begin
        growing = $urandom_range(0, 1);
        spell_left = $urandom_range(40, 220);
      end
      spell_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        act = pick[0] ? ACT_UNUSED_7 : ACT_UNUSED_6;
      end else if (pick < (growing ? 58 : 23)) begin
        act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      end else if (pick < 70) begin
        act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
      end else begin
        act = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
      end
      if (mirror_fill != 0 && $urandom_range(0, 9) != 0) begin
        pos = POS_W'($urandom_range(0, int'(mirror_fill) - 1));
      end else begin
        pos = POS_W'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 15))
        0:       word = 32'h0000_0000;
        1:       word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      send_beat(act, pos, word);
    end
  endtask

  // Receiver: change stall mode every so often. Modes are always ready,
  // one stall in four, coin flip, and long stalls that hold ready low two thirds of the time.
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(30, 200);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= (stall_tick % 4) != 3;
        2:       out_ready <= $urandom_range(0, 1);
        default: out_ready <= (stall_tick % 12) >= 8;
      endcase
    end
  end

  // Compare each result beat, field by field, against the oldest expectation.
  always @(posedge clk) begin : check_results
    dq_result_t head;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected (word %h fill %0d error %b)",
                 $time, out_word_out, out_fill_count, out_error);
        error_count++;
      end else begin
        head = pending_results.pop_front();
        results_checked++;
        if (out_word_out !== head.word) begin
          $display("%0t: word_out mismatch, expected %h, got %h",
                   $time, head.word, out_word_out);
          error_count++;
        end
        if (out_fill_count !== head.fill) begin
          $display("%0t: fill_count mismatch, expected %0d, got %0d",
                   $time, head.fill, out_fill_count);
          error_count++;
        end
        if (out_error !== head.err) begin
          $display("%0t: error mismatch, expected %b, got %b",
                   $time, head.err, out_error);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no beat on either channel for %0d cycles",
                 $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    // Hold reset low at first, then release it at a rising edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    wait_for_results();
    test_fill_and_drain();
    wait_for_results();
    test_random_traffic(1100);
    wait_for_results();
    // Let any stray late beat show up before the verdict.
    repeat (8) @(posedge clk);

    $display("Run covered %0d beats and %0d checked results, %0d of them refused.",
             beats_sent, results_checked, refused_count);
    $display("Fill peaked at %0d words, with %0d results reporting a full queue.",
             peak_fill, full_hits);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
